// File: rtl/deadband_change_reporter_unit_defines.svh
// assertion macros shared by the deadband change reporter rtl
`ifndef DEADBAND_CHANGE_REPORTER_UNIT_DEFINES_SVH
`define DEADBAND_CHANGE_REPORTER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DCR_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle check failed");
`define DCR_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define DCR_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define DCR_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/dcr_pkg.sv
// package: widths, codes, reset values and types of the deadband change reporter
`timescale 1ns / 1ps
package dcr_pkg;

  localparam int VALUE_W     = 10;
  localparam int CHAN_W      = 3;
  localparam int BYTE_W      = 8;
  localparam int CHANNELS_DEF = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_ID = 1'd1;

  localparam logic [VALUE_W-1:0] DEADBAND_RESET  = 10'd2;
  localparam logic [BYTE_W-1:0]  SWITCH_ID_RESET = 8'd9;

  localparam logic [BYTE_W-1:0] FRAME_START = 8'hff;
  localparam logic [BYTE_W-1:0] FRAME_END   = 8'hfe;

  localparam int QUEUE_DEPTH = 2;

  // byte positions within a frame
  localparam int POS_W = 3;
  localparam logic [POS_W-1:0] POS_START = 3'd0;
  localparam logic [POS_W-1:0] POS_B1    = 3'd1;
  localparam logic [POS_W-1:0] POS_B2    = 3'd2;
  localparam logic [POS_W-1:0] POS_B3    = 3'd3;
  localparam logic [POS_W-1:0] POS_END   = 3'd4;

  // the three variable bytes of one frame
  typedef struct packed {
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } frame_t;

endpackage

// File: rtl/dcr_if.sv
// valid/ready channel interfaces for sample words and frame bytes
`timescale 1ns / 1ps
interface dcr_in_if import dcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CHAN_W-1:0]  channel;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output channel, output value, input ready);
  modport sink (input valid, input kind, input channel, input value, output ready);
endinterface

interface dcr_out_if import dcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last;

  modport source (output valid, output frame_byte, output last, input ready);
  modport sink (input valid, input frame_byte, input last, output ready);
endinterface

// File: rtl/dcr_front.sv
// front end: config registers, per-channel stored values and change classification
`timescale 1ns / 1ps
module dcr_front import dcr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dcr_in_if.sink                in_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  push,
  output frame_t                push_data,
  input  logic                  q_full
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W = 5;

  logic [VALUE_W-1:0] deadband_r;
  logic [BYTE_W-1:0]  switch_id_r;
  logic [VALUE_W-1:0] last_r [CHANNELS];

  logic               accept;
  logic [CMP_W-1:0]   ch_ext;
  logic [IDX_W-1:0]   idx;
  logic               ch_ok;
  logic [VALUE_W-1:0] prev;
  logic signed [VALUE_W+1:0] v_s, lo_s, hi_s;
  logic               report;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  assign ch_ext = CMP_W'(in_chan.channel);
  assign idx    = ch_ext[IDX_W-1:0];
  assign ch_ok  = ch_ext < CMP_W'(CHANNELS);
  assign prev   = last_r[idx];

  // band edges in signed arithmetic so nothing wraps
  always_comb begin
    v_s  = signed'({2'b00, in_chan.value});
    lo_s = signed'({2'b00, prev}) - signed'({2'b00, deadband_r});
    hi_s = signed'({2'b00, prev}) + signed'({2'b00, deadband_r});
    report = ch_ok && ((v_s < lo_s) || (v_s > hi_s));
  end

  always_comb begin
    if (in_chan.kind) begin
      push_data.b1 = switch_id_r;
      push_data.b2 = '0;
      push_data.b3 = in_chan.value[BYTE_W-1:0];
    end else begin
      push_data.b1 = BYTE_W'(in_chan.channel);
      push_data.b2 = BYTE_W'(in_chan.value[VALUE_W-1:BYTE_W]);
      push_data.b3 = in_chan.value[BYTE_W-1:0];
    end
  end

  assign push = accept && (in_chan.kind || report);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r  <= DEADBAND_RESET;
      switch_id_r <= SWITCH_ID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEADBAND:  deadband_r  <= cfg_wdata[VALUE_W-1:0];
        REG_SWITCH_ID: switch_id_r <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_r[i] <= '0;
      end
    end else if (accept && !in_chan.kind && report) begin
      last_r[idx] <= in_chan.value;
    end
  end

endmodule

// File: rtl/dcr_queue.sv
// short frame queue between the classifier and the byte sequencer
`timescale 1ns / 1ps
module dcr_queue import dcr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  input  logic   pop,
  output frame_t head,
  output logic   empty
);
`include "deadband_change_reporter_unit_defines.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `DCR_ASSERT_IMPLIES(a_no_push_full, clk, rst_n, full, !push)
  `DCR_ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, empty, !pop)

endmodule

// File: rtl/dcr_back.sv
// back end: walks one queued frame out as five bytes
`timescale 1ns / 1ps
module dcr_back import dcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  frame_t    head,
  input  logic      empty,
  output logic      pop,
  dcr_out_if.source out_chan
);
`include "deadband_change_reporter_unit_defines.svh"

  logic             busy_r, busy_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  frame_t           frm_r;
  logic             fire, done;

  assign out_chan.valid = busy_r;
  assign out_chan.last  = pos_r == POS_END;
  assign fire = out_chan.valid && out_chan.ready;
  assign done = fire && (pos_r == POS_END);
  // next frame loads in the same cycle the closing byte leaves
  assign pop  = !empty && (!busy_r || done);

  always_comb begin
    unique case (pos_r)
      POS_START: out_chan.frame_byte = FRAME_START;
      POS_B1:    out_chan.frame_byte = frm_r.b1;
      POS_B2:    out_chan.frame_byte = frm_r.b2;
      POS_B3:    out_chan.frame_byte = frm_r.b3;
      POS_END:   out_chan.frame_byte = FRAME_END;
      default:   out_chan.frame_byte = FRAME_END;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (pop) begin
      busy_nxt = 1'b1;
      pos_nxt  = POS_START;
    end else if (done) begin
      busy_nxt = 1'b0;
      pos_nxt  = POS_START;
    end else if (fire) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= POS_START;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frm_r <= head;
    end
  end

  `DCR_ASSERT_NEXT(a_frame_continues, clk, rst_n, fire && !out_chan.last, out_chan.valid)
  `DCR_ASSERT_NEXT(a_stall_holds_pos, clk, rst_n, out_chan.valid && !out_chan.ready,
                   $stable(pos_r))
  `DCR_ASSERT_NEXT(a_restart_at_start, clk, rst_n, done, pos_r == POS_START)

endmodule

// File: rtl/deadband_change_reporter_unit.sv
// top level of the deadband change reporter
`timescale 1ns / 1ps
// Accepts analog samples and switch snapshots one word per cycle while the two-entry
// frame queue has room. A sample that stays inside its channel's deadband, or names a
// channel not below CHANNELS, is absorbed in its accept cycle with no output. A sample
// outside the band becomes a five-byte frame (0xff, channel, high, low, 0xfe) and each
// snapshot one of (0xff, id, 0x00, low, 0xfe), sent one byte per cycle while the
// receiver is ready, as paced by the output byte sequencer; the queue lets up to two
// frames build up behind a stalled output. Stored channel values clear during reset.
module deadband_change_reporter_unit import dcr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dcr_in_if.sink                in_chan,
  dcr_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic   push, q_full, pop, q_empty;
  frame_t push_data, q_head;

  dcr_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  dcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  dcr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// File: dv/deadband_change_reporter_unit_tb.sv
// testbench for the deadband change reporter: directed table, random phases, byte-level check
`timescale 1ns / 1ps
module deadband_change_reporter_unit_tb;
  import dcr_pkg::*;

  localparam int N_CHAN = CHANNELS_DEF;
  localparam int N_DIR = 22;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [BYTE_W-1:0] fb;
    logic              lst;
  } frame_word_t;

  typedef struct packed {
    bit                kind;
    bit [CHAN_W-1:0]   chan;
    bit [VALUE_W-1:0]  val;
    bit                typed;
    bit                reports;
    bit [BYTE_W-1:0]   b1;
    bit [BYTE_W-1:0]   b2;
    bit [BYTE_W-1:0]   b3;
  } dir_row_t;

  typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dcr_in_if  in_if ();
  dcr_out_if out_if ();

  deadband_change_reporter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [VALUE_W-1:0] stored_level [N_CHAN];
  logic [VALUE_W-1:0] deadband_reg;
  logic [BYTE_W-1:0]  switch_id_reg;

  frame_word_t expected_bytes [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // kind, channel, value, typed, reports, b1, b2, b3 (typed rows use reset config)
  dir_row_t dir_rows [0:N_DIR-1] = '{
    '{1'b0, 3'd0, 10'd0,    1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd0, 10'd2,    1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd0, 10'd3,    1'b1, 1'b1, 8'h00, 8'h00, 8'h03},
    '{1'b0, 3'd7, 10'd1023, 1'b1, 1'b1, 8'h07, 8'h03, 8'hff},
    '{1'b0, 3'd7, 10'd1021, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd7, 10'd1020, 1'b1, 1'b1, 8'h07, 8'h03, 8'hfc},
    '{1'b1, 3'd0, 10'h3ff,  1'b1, 1'b1, 8'h09, 8'h00, 8'hff},
    '{1'b1, 3'd7, 10'h000,  1'b1, 1'b1, 8'h09, 8'h00, 8'h00},
    '{1'b1, 3'd5, 10'h155,  1'b1, 1'b1, 8'h09, 8'h00, 8'h55},
    '{1'b0, 3'd1, 10'h2aa,  1'b1, 1'b1, 8'h01, 8'h02, 8'haa},
    '{1'b0, 3'd2, 10'h155,  1'b1, 1'b1, 8'h02, 8'h01, 8'h55},
    '{1'b0, 3'd0, 10'd1,    1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd0, 10'd0,    1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd3, 10'd512,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd4, 10'd256,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd5, 10'd1000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd6, 10'd4,    1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd3, 10'd514,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd3, 10'd515,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd6, 10'd1,    1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 3'd6, 10'd1023, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{1'b1, 3'd2, 10'h2aa,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void push_frame(input logic [BYTE_W-1:0] b1,
                                     input logic [BYTE_W-1:0] b2,
                                     input logic [BYTE_W-1:0] b3);
    expected_bytes.push_back('{FRAME_START, 1'b0});
    expected_bytes.push_back('{b1, 1'b0});
    expected_bytes.push_back('{b2, 1'b0});
    expected_bytes.push_back('{b3, 1'b0});
    expected_bytes.push_back('{FRAME_END, 1'b1});
  endfunction

  // updates stored levels; queues the frame only when asked
  function automatic void predict_report(input bit kind, input logic [CHAN_W-1:0] ch,
                                         input logic [VALUE_W-1:0] v, input bit queue_it);
    int cur;
    int prev;
    int band;
    if (kind) begin
      if (queue_it) push_frame(switch_id_reg, 8'h00, v[7:0]);
      return;
    end
    if (int'(ch) >= N_CHAN) return;
    cur = int'(v);
    prev = int'(stored_level[ch]);
    band = int'(deadband_reg);
    if (cur < prev - band || cur > prev + band) begin
      stored_level[ch] = v;
      if (queue_it) push_frame(BYTE_W'(ch), BYTE_W'(v[9:8]), v[7:0]);
    end
  endfunction

  function automatic void set_pace(input pace_t p);
    case (p)
      PACE_SLOW_SINK: begin
        send_idle_pct = 18;
        recv_idle_pct = 80;
      end
      PACE_SLOW_SOURCE: begin
        send_idle_pct = 80;
        recv_idle_pct = 18;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  task automatic send_word(input bit kind, input logic [CHAN_W-1:0] ch,
                           input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.channel <= ch;
    in_if.value   <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (expected_bytes.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    // words inside the band leave no trace, so give the block time to settle
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [VALUE_W-1:0] db, input logic [BYTE_W-1:0] id);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEADBAND;
    cfg_wdata <= CFG_DATA_W'(db);
    @(posedge clk);
    cfg_index <= REG_SWITCH_ID;
    cfg_wdata <= CFG_DATA_W'(id);
    @(posedge clk);
    cfg_we <= 1'b0;
    deadband_reg  = db;
    switch_id_reg = id;
  endtask

  task automatic run_random(input int n_words);
    int r;
    int lvl;
    int off;
    bit kind;
    logic [CHAN_W-1:0]  ch;
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < n_words; i++) begin
      r = $urandom_range(99);
      kind = (r < 20);
      ch = CHAN_W'($urandom_range(N_CHAN - 1));
      v = VALUE_W'($urandom_range(1023));
      if (!kind && r < 65) begin
        // land just inside, on, or just outside a band edge
        off = int'(deadband_reg) + int'($urandom_range(2)) - 1;
        if (off < 0) off = 0;
        lvl = $urandom_range(1) ? int'(stored_level[ch]) + off
                                : int'(stored_level[ch]) - off;
        if (lvl < 0) lvl = 0;
        if (lvl > 1023) lvl = 1023;
        v = VALUE_W'(lvl);
      end
      predict_report(kind, ch, v, 1'b1);
      send_word(kind, ch, v);
    end
    in_if.valid <= 1'b0;
    wait_drained();
  endtask

  // receiver: random ready, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    frame_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual byte %h last %b",
                 $time, out_if.frame_byte, out_if.last);
      end else begin
        want = expected_bytes.pop_front();
        if (out_if.frame_byte !== want.fb) begin
          errors++;
          $display("%0t: frame_byte mismatch, expected %h, actual %h",
                   $time, want.fb, out_if.frame_byte);
        end
        if (out_if.last !== want.lst) begin
          errors++;
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, want.lst, out_if.last);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.channel = '0;
    in_if.value = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_DEADBAND;
    cfg_wdata = '0;
    for (int i = 0; i < N_CHAN; i++) stored_level[i] = '0;
    deadband_reg = DEADBAND_RESET;
    switch_id_reg = SWITCH_ID_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_pace(PACE_SLOW_SINK);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        predict_report(dir_rows[i].kind, dir_rows[i].chan, dir_rows[i].val, 1'b0);
        if (dir_rows[i].reports) push_frame(dir_rows[i].b1, dir_rows[i].b2, dir_rows[i].b3);
      end else begin
        predict_report(dir_rows[i].kind, dir_rows[i].chan, dir_rows[i].val, 1'b1);
      end
      send_word(dir_rows[i].kind, dir_rows[i].chan, dir_rows[i].val);
    end
    in_if.valid <= 1'b0;
    wait_drained();

    // zero band: every change reports
    set_config(10'd0, 8'd0);
    set_pace(PACE_SLOW_SOURCE);
    run_random(45);

    // widest band: only snapshots report; output held off to back up the input
    set_config(10'd1023, 8'd255);
    set_pace(PACE_FULL);
    hold_reqs++;
    run_random(30);

    set_config(VALUE_W'($urandom_range(1, 30)), BYTE_W'($urandom_range(255)));
    set_pace(PACE_SLOW_SINK);
    run_random(45);

    set_config(10'd1, 8'ha5);
    set_pace(PACE_SLOW_SOURCE);
    run_random(40);

    set_config(VALUE_W'($urandom_range(2, 8)), BYTE_W'($urandom_range(255)));
    set_pace(PACE_FULL);
    hold_reqs++;
    run_random(40);

    if (expected_bytes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived, expected %h, actual none",
               $time, expected_bytes.size(), expected_bytes[0].fb);
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
